// File: src/v3au_pkg.sv
// ----------------------------------------------------------------------------
// v3au_pkg
// shared operation codes and fixed-point defaults for the 3d vector unit
// ----------------------------------------------------------------------------
package v3au_pkg;

  // default number of fraction bits of the signed fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // square-root chain: one result bit per stage, 32 result bits
  localparam int SQ_STEPS = 32;

  typedef enum logic [3:0] {
    FUNC_ADD   = 4'd0,
    FUNC_SUB   = 4'd1,
    FUNC_MUL   = 4'd2,
    FUNC_DIV   = 4'd3,
    FUNC_SCALE = 4'd4,
    FUNC_DOT   = 4'd5,
    FUNC_CROSS = 4'd6,
    FUNC_TRI   = 4'd7,
    FUNC_MAG   = 4'd8,
    FUNC_NORM  = 4'd9,
    FUNC_CLIP  = 4'd10,
    FUNC_MIN   = 4'd11,
    FUNC_MAX   = 4'd12,
    FUNC_ZERO  = 4'd13
  } func_t;

  // pipeline latency in cycles from accepted transaction to result strobe
  function automatic int calc_latency(input int frac_bits);
    return 4 + SQ_STEPS + frac_bits + 1;
  endfunction

endpackage

// File: src/vector3_arith_unit_core.sv
// ----------------------------------------------------------------------------
// vector3_arith_unit_core
// pipelined 3d vector alu: add, sub, products, divide, dot, cross, normal,
// magnitude, normalize, clip, min, max and zero test on signed fixed point
// ----------------------------------------------------------------------------
// the latency from start to out_valid is the same for every func
// throughput: one transaction per cycle; busy is never raised
// the pipe holds the 32-stage square-root chain followed by the
// FRAC_BITS + 1 stage normalize divider, one bit per stage
// results cannot be stalled: out_valid pulses for one cycle per transaction
// reset (rst_n, synchronous) clears the valid bits only; data stages are free
module vector3_arith_unit_core
  import v3au_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_func,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_c_x,
  input  logic signed [31:0] in_c_y,
  input  logic signed [31:0] in_c_z,
  input  logic signed [31:0] in_factor,
  output logic        out_valid,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic signed [31:0] out_scalar_out,
  output logic        out_is_zero,
  output logic        out_div_zero,
  output logic        out_saturated
);

  // quotient width of the element divide, bit count of the normalize quotient
  localparam int QW       = 32 + FRAC_BITS;
  localparam int NW       = FRAC_BITS + 1;
  localparam int SQ_FIRST = 4;
  localparam int NM_FIRST = SQ_FIRST + SQ_STEPS;
  localparam int LAT      = calc_latency(FRAC_BITS);

  localparam logic signed [31:0] MAX32  = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32  = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_FX = 32'sh1 << FRAC_BITS;
  localparam logic signed [66:0] MAX_W  = 67'sd2147483647;
  localparam logic signed [66:0] MIN_W  = -67'sd2147483648;

  // everything one transaction carries down the pipe
  typedef struct packed {
    logic [3:0]            func;
    logic                  zero;
    logic [2:0][31:0]      r;
    logic [31:0]           scalar;
    logic                  sat;
    logic [5:0][31:0]      opa;
    logic [5:0][31:0]      opb;
    logic [5:0][63:0]      prod;
    logic [63:0]           sq_s;
    logic [33:0]           sq_rem;
    logic [31:0]           sq_root;
    logic [2:0][31:0]      mg;
    logic [2:0]            aneg;
    logic [2:0]            bz;
    logic [2:0]            neg;
    logic [2:0][QW-1:0]    dv_num;
    logic [2:0][QW-1:0]    dv_q;
    logic [2:0][31:0]      dv_rem;
    logic [2:0][31:0]      dv_d;
    logic [2:0][31:0]      nm_rem;
    logic [2:0][NW-1:0]    nm_num;
    logic [2:0][NW-1:0]    nm_q;
  } pipe_t;

  // clamp a wide signed value to 32 bits; msb of the result is the clamp flag
  function automatic logic [32:0] sat_to32(input logic signed [66:0] v);
    logic [32:0] res;
    if (v > MAX_W) begin
      res = {1'b1, MAX32};
    end else if (v < MIN_W) begin
      res = {1'b1, MIN32};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  pipe_t           pipe_r [1:LAT-1];
  logic [LAT-1:1]  vld_r;
  pipe_t           front_nxt;

  logic signed [31:0] out_r_x_r, out_r_y_r, out_r_z_r, out_scalar_r;
  logic               out_valid_r, out_is_zero_r, out_div_zero_r, out_saturated_r;

  // a new transaction can enter every cycle
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // stage 1: simple element ops, triangle edges, multiplier operand select,
  // divider set-up
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [31:0] cv [3];
    logic signed [31:0] e1 [3];
    logic signed [31:0] e2 [3];
    logic [32:0]        sr;
    av = '{in_a_x, in_a_y, in_a_z};
    bv = '{in_b_x, in_b_y, in_b_z};
    cv = '{in_c_x, in_c_y, in_c_z};
    front_nxt        = '0;
    front_nxt.func   = in_func;
    front_nxt.zero   = (in_a_x == 32'sd0) && (in_a_y == 32'sd0) && (in_a_z == 32'sd0);

    for (int i = 0; i < 3; i++) begin
      sr    = sat_to32(67'(av[i]) - 67'(bv[i]));
      e1[i] = sr[31:0];
      sr    = sat_to32(67'(cv[i]) - 67'(bv[i]));
      e2[i] = sr[31:0];
      // default pairing for element products and squares
      front_nxt.opa[i] = av[i];
      front_nxt.opb[i] = bv[i];
      // divider and normalize set-up
      front_nxt.mg[i]     = av[i][31] ? 32'(-av[i]) : av[i];
      front_nxt.aneg[i]   = av[i][31];
      front_nxt.bz[i]     = (bv[i] == 32'sd0);
      front_nxt.neg[i]    = av[i][31] ^ bv[i][31];
      front_nxt.dv_d[i]   = bv[i][31] ? 32'(-bv[i]) : bv[i];
      front_nxt.dv_num[i] = QW'(front_nxt.mg[i]) << FRAC_BITS;
    end

    unique case (func_t'(in_func)) inside
      FUNC_ADD: begin
        for (int i = 0; i < 3; i++) begin
          sr = sat_to32(67'(av[i]) + 67'(bv[i]));
          front_nxt.r[i] = sr[31:0];
          front_nxt.sat  = front_nxt.sat | sr[32];
        end
      end
      FUNC_SUB: begin
        for (int i = 0; i < 3; i++) begin
          sr = sat_to32(67'(av[i]) - 67'(bv[i]));
          front_nxt.r[i] = sr[31:0];
          front_nxt.sat  = front_nxt.sat | sr[32];
        end
      end
      FUNC_SCALE: begin
        for (int i = 0; i < 3; i++) front_nxt.opb[i] = in_factor;
      end
      FUNC_MAG, FUNC_NORM: begin
        for (int i = 0; i < 3; i++) front_nxt.opb[i] = av[i];
      end
      FUNC_CROSS: begin
        front_nxt.opa = {av[1], av[0], av[0], av[2], av[2], av[1]};
        front_nxt.opb = {bv[0], bv[1], bv[2], bv[0], bv[1], bv[2]};
      end
      FUNC_TRI: begin
        for (int i = 0; i < 3; i++) begin
          sr = sat_to32(67'(av[i]) - 67'(bv[i]));
          front_nxt.sat = front_nxt.sat | sr[32];
          sr = sat_to32(67'(cv[i]) - 67'(bv[i]));
          front_nxt.sat = front_nxt.sat | sr[32];
        end
        front_nxt.opa = {e1[1], e1[0], e1[0], e1[2], e1[2], e1[1]};
        front_nxt.opb = {e2[0], e2[1], e2[2], e2[0], e2[1], e2[2]};
      end
      FUNC_CLIP: begin
        for (int i = 0; i < 3; i++) begin
          front_nxt.r[i] = (av[i] > ONE_FX) ? ONE_FX : (av[i][31] ? 32'sd0 : av[i]);
        end
      end
      FUNC_MIN: begin
        for (int i = 0; i < 3; i++) front_nxt.r[i] = (av[i] < bv[i]) ? av[i] : bv[i];
      end
      FUNC_MAX: begin
        for (int i = 0; i < 3; i++) front_nxt.r[i] = (av[i] > bv[i]) ? av[i] : bv[i];
      end
      default: begin
        // mul, dot, div, zero test and unused codes need nothing here
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pipe_r[1] <= front_nxt;
  end

  // --------------------------------------------------------------------------
  // stages 2 .. LAT-1
  //   2: six 32x32 products
  //   3: sums and differences of products, drop fraction, saturate
  //   4 .. 35: square root, one result bit per stage
  //   36 .. 36+FRAC_BITS: normalize divide, one quotient bit per stage
  //   element divide runs alongside from stage 2, one bit per stage
  // --------------------------------------------------------------------------
  for (genvar k = 2; k < LAT; k++) begin : g_stage
    pipe_t stg_nxt;

    always_comb begin
      logic signed [63:0] xa, xb;
      logic signed [66:0] w;
      logic [32:0]        sr;
      logic [32:0]        t;
      logic [34:0]        st;
      logic [34:0]        trial;
      stg_nxt = pipe_r[k-1];
      xa      = '0;
      xb      = '0;
      w       = '0;
      sr      = '0;
      t       = '0;
      st      = '0;
      trial   = '0;

      if (k == 2) begin
        for (int j = 0; j < 6; j++) begin
          xa = 64'($signed(pipe_r[k-1].opa[j]));
          xb = 64'($signed(pipe_r[k-1].opb[j]));
          stg_nxt.prod[j] = xa * xb;
        end
      end

      if (k == 3) begin
        stg_nxt.sq_s    = pipe_r[k-1].prod[0] + pipe_r[k-1].prod[1] + pipe_r[k-1].prod[2];
        stg_nxt.sq_rem  = '0;
        stg_nxt.sq_root = '0;
        case (func_t'(pipe_r[k-1].func)) inside
          FUNC_MUL, FUNC_SCALE: begin
            for (int i = 0; i < 3; i++) begin
              w  = 67'($signed(pipe_r[k-1].prod[i])) >>> FRAC_BITS;
              sr = sat_to32(w);
              stg_nxt.r[i] = sr[31:0];
              stg_nxt.sat  = stg_nxt.sat | sr[32];
            end
          end
          FUNC_DOT: begin
            w = 67'($signed(pipe_r[k-1].prod[0])) + 67'($signed(pipe_r[k-1].prod[1]))
              + 67'($signed(pipe_r[k-1].prod[2]));
            w = w >>> FRAC_BITS;
            sr = sat_to32(w);
            stg_nxt.scalar = sr[31:0];
            stg_nxt.sat    = stg_nxt.sat | sr[32];
          end
          FUNC_CROSS, FUNC_TRI: begin
            for (int i = 0; i < 3; i++) begin
              w = 67'($signed(pipe_r[k-1].prod[2*i]))
                - 67'($signed(pipe_r[k-1].prod[2*i+1]));
              w = w >>> FRAC_BITS;
              sr = sat_to32(w);
              stg_nxt.r[i] = sr[31:0];
              stg_nxt.sat  = stg_nxt.sat | sr[32];
            end
          end
          default: begin
          end
        endcase
      end

      if (k >= SQ_FIRST && k < SQ_FIRST + SQ_STEPS) begin
        st    = {pipe_r[k-1].sq_rem[32:0], pipe_r[k-1].sq_s[63:62]};
        trial = {1'b0, pipe_r[k-1].sq_root, 2'b01};
        stg_nxt.sq_s = pipe_r[k-1].sq_s << 2;
        if (st >= trial) begin
          stg_nxt.sq_rem  = 34'(st - trial);
          stg_nxt.sq_root = {pipe_r[k-1].sq_root[30:0], 1'b1};
        end else begin
          stg_nxt.sq_rem  = st[33:0];
          stg_nxt.sq_root = {pipe_r[k-1].sq_root[30:0], 1'b0};
        end
      end

      if (k - 1 <= QW) begin
        for (int i = 0; i < 3; i++) begin
          t = {pipe_r[k-1].dv_rem[i], pipe_r[k-1].dv_num[i][QW-1]};
          stg_nxt.dv_num[i] = pipe_r[k-1].dv_num[i] << 1;
          if (t >= {1'b0, pipe_r[k-1].dv_d[i]}) begin
            stg_nxt.dv_rem[i] = 32'(t - {1'b0, pipe_r[k-1].dv_d[i]});
            stg_nxt.dv_q[i]   = {pipe_r[k-1].dv_q[i][QW-2:0], 1'b1};
          end else begin
            stg_nxt.dv_rem[i] = t[31:0];
            stg_nxt.dv_q[i]   = {pipe_r[k-1].dv_q[i][QW-2:0], 1'b0};
          end
        end
      end

      if (k == NM_FIRST) begin
        // quotient stays within FRAC_BITS+1 bits, so start from mg / 2
        for (int i = 0; i < 3; i++) begin
          stg_nxt.nm_rem[i] = pipe_r[k-1].mg[i] >> 1;
          stg_nxt.nm_num[i] = NW'(pipe_r[k-1].mg[i][0]) << FRAC_BITS;
          stg_nxt.nm_q[i]   = '0;
        end
      end

      if (k >= NM_FIRST) begin
        for (int i = 0; i < 3; i++) begin
          t = {stg_nxt.nm_rem[i], stg_nxt.nm_num[i][NW-1]};
          stg_nxt.nm_num[i] = stg_nxt.nm_num[i] << 1;
          if (t >= {1'b0, pipe_r[k-1].sq_root}) begin
            stg_nxt.nm_rem[i] = 32'(t - {1'b0, pipe_r[k-1].sq_root});
            stg_nxt.nm_q[i]   = NW'({stg_nxt.nm_q[i], 1'b1});
          end else begin
            stg_nxt.nm_rem[i] = t[31:0];
            stg_nxt.nm_q[i]   = NW'({stg_nxt.nm_q[i], 1'b0});
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      pipe_r[k] <= stg_nxt;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[LAT-2:1], start & ~busy};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // --------------------------------------------------------------------------
  // output stage: sign and clamp of quotients, magnitude clamp, final select
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    logic [2:0][31:0] rv;
    logic [31:0]      sv;
    logic             dz;
    logic             sat;
    logic [QW-1:0]    q;
    rv  = pipe_r[LAT-1].r;
    sv  = pipe_r[LAT-1].scalar;
    dz  = 1'b0;
    sat = pipe_r[LAT-1].sat;
    case (func_t'(pipe_r[LAT-1].func))
      FUNC_DIV: begin
        for (int i = 0; i < 3; i++) begin
          q = pipe_r[LAT-1].dv_q[i];
          if (pipe_r[LAT-1].bz[i]) begin
            // zero divisor: clamp by the sign of the dividend
            rv[i] = pipe_r[LAT-1].aneg[i] ? MIN32 : MAX32;
            dz    = 1'b1;
          end else if (pipe_r[LAT-1].neg[i]) begin
            if (q > QW'(64'h8000_0000)) begin
              rv[i] = MIN32;
              sat   = 1'b1;
            end else begin
              rv[i] = -q[31:0];
            end
          end else if (q > QW'(64'h7fff_ffff)) begin
            rv[i] = MAX32;
            sat   = 1'b1;
          end else begin
            rv[i] = q[31:0];
          end
        end
      end
      FUNC_MAG: begin
        if (pipe_r[LAT-1].sq_root[31]) begin
          sv  = MAX32;
          sat = 1'b1;
        end else begin
          sv = pipe_r[LAT-1].sq_root;
        end
      end
      FUNC_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (pipe_r[LAT-1].sq_root == 32'd0) begin
            rv[i] = '0;
          end else if (pipe_r[LAT-1].aneg[i]) begin
            rv[i] = -(32'(pipe_r[LAT-1].nm_q[i]));
          end else begin
            rv[i] = 32'(pipe_r[LAT-1].nm_q[i]);
          end
        end
      end
      default: begin
      end
    endcase
    out_r_x_r       <= rv[0];
    out_r_y_r       <= rv[1];
    out_r_z_r       <= rv[2];
    out_scalar_r    <= sv;
    out_is_zero_r   <= pipe_r[LAT-1].zero;
    out_div_zero_r  <= dz;
    out_saturated_r <= sat;
  end

  assign out_valid      = out_valid_r;
  assign out_r_x        = out_r_x_r;
  assign out_r_y        = out_r_y_r;
  assign out_r_z        = out_r_z_r;
  assign out_scalar_out = out_scalar_r;
  assign out_is_zero    = out_is_zero_r;
  assign out_div_zero   = out_div_zero_r;
  assign out_saturated  = out_saturated_r;

endmodule

// File: src/v3au_checker.sv
// ----------------------------------------------------------------------------
// v3au_checker
// port-level checks of the vector unit pipeline, bound to the top level
// ----------------------------------------------------------------------------
module v3au_checker
  import v3au_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [3:0]  in_func,
  input logic signed [31:0] in_a_x,
  input logic signed [31:0] in_a_y,
  input logic signed [31:0] in_a_z,
  input logic signed [31:0] in_b_x,
  input logic signed [31:0] in_b_y,
  input logic signed [31:0] in_b_z,
  input logic signed [31:0] in_c_x,
  input logic signed [31:0] in_c_y,
  input logic signed [31:0] in_c_z,
  input logic signed [31:0] in_factor,
  input logic        out_valid,
  input logic signed [31:0] out_r_x,
  input logic signed [31:0] out_r_y,
  input logic signed [31:0] out_r_z,
  input logic signed [31:0] out_scalar_out,
  input logic        out_is_zero,
  input logic        out_div_zero,
  input logic        out_saturated
);

  localparam int LAT = calc_latency(FRAC_BITS);

  // every result strobe belongs to an earlier accepted transaction
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without matching transaction");

  // the zero divisor flag comes only from an element divide
  a_div_zero_func: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_zero) |-> ($past(in_func, LAT) == FUNC_DIV))
    else $error("div_zero raised for a non-divide transaction");

  // zero test flag follows vector a of the same transaction
  a_is_zero_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_zero == ($past(in_a_x, LAT) == 32'sd0 &&
                                   $past(in_a_y, LAT) == 32'sd0 &&
                                   $past(in_a_z, LAT) == 32'sd0)))
    else $error("is_zero does not match vector a");

  // scalar ops leave the vector at zero
  a_scalar_ops_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_func, LAT) == FUNC_DOT || $past(in_func, LAT) == FUNC_MAG))
      |-> (out_r_x == 32'sd0 && out_r_y == 32'sd0 && out_r_z == 32'sd0))
    else $error("vector not zero for a scalar operation");

endmodule

bind vector3_arith_unit_core v3au_checker #(.FRAC_BITS(FRAC_BITS)) u_v3au_checker (.*);
